// ===== design/dfr_pkg.sv =====
// Shared types, codes and the CRC-32 byte update for the frame deframer.
package dfr_pkg;

  // Reflected CRC-32 polynomial and the all-ones init / final xor value.
  localparam logic [31:0] CRC_POLY = 32'hEDB88320;
  localparam logic [31:0] CRC_ONES = 32'hFFFFFFFF;

  // Register reset values.
  localparam logic [31:0] PREFIX_RESET  = 32'h000055AA;
  localparam logic [31:0] SUFFIX_RESET  = 32'h0000AA55;
  localparam logic [15:0] MAX_LEN_RESET = 16'd4096;

  // Frame layout: header ends at byte 15, the return code at byte 19.
  localparam logic [16:0] POS_PREFIX_END = 17'd3;
  localparam logic [16:0] POS_SEQ_END    = 17'd7;
  localparam logic [16:0] POS_CMD_END    = 17'd11;
  localparam logic [16:0] POS_LEN_END    = 17'd15;
  localparam logic [16:0] POS_RET_END    = 17'd19;
  localparam logic [16:0] POS_SHORT_LIM  = 17'd27;
  localparam logic [31:0] MIN_LENGTH     = 32'd12;

  // Register indexes of the configuration port.
  typedef enum logic [1:0] {
    REG_PREFIX  = 2'd0,
    REG_SUFFIX  = 2'd1,
    REG_MAX_LEN = 2'd2
  } reg_idx_t;

  // Result kinds.
  typedef enum logic [1:0] {
    KIND_PAYLOAD  = 2'd0,
    KIND_COMPLETE = 2'd1,
    KIND_ERROR    = 2'd2
  } kind_t;

  // Error codes carried with an error status.
  typedef enum logic [2:0] {
    ERR_NONE      = 3'd0,
    ERR_SHORT     = 3'd1,
    ERR_PREFIX    = 3'd2,
    ERR_TRUNCATED = 3'd3,
    ERR_LEN_SMALL = 3'd4,
    ERR_SUFFIX    = 3'd5,
    ERR_LEN_MAX   = 3'd6
  } err_t;

  // Live configuration.
  typedef struct packed {
    logic [31:0] prefix;
    logic [31:0] suffix;
    logic [15:0] max_len;
  } cfg_t;

  // One result item.
  typedef struct packed {
    kind_t       kind;
    logic [7:0]  payload;
    logic [31:0] seq;
    logic [31:0] cmd;
    logic [31:0] ret;
    logic        ok;
    err_t        err;
  } res_t;

  // One byte of the reflected CRC-32, LSB first.
  function automatic logic [31:0] crc32_byte(input logic [31:0] crc_in,
                                             input logic [7:0]  data);
    logic [31:0] c;
    c = crc_in ^ {24'd0, data};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

// ===== design/dfr_front.sv =====
// Front end: accepts received bytes, parses the frame and forms result items.
module dfr_front (
  input  logic          clk,
  input  logic          rst_n,
  input  dfr_pkg::cfg_t cfg,
  input  logic          in_fire,
  input  logic [7:0]    rx_byte,
  input  logic          buffer_last,
  output logic          res_valid,
  output dfr_pkg::res_t res
);
  import dfr_pkg::*;

  typedef enum logic [2:0] {
    ST_HEADER  = 3'd0,
    ST_RETCODE = 3'd1,
    ST_DATA    = 3'd2,
    ST_CRC     = 3'd3,
    ST_SUFFIX  = 3'd4
  } stage_t;

  stage_t      stage_r, stage_nxt;
  logic [16:0] pos_r, pos_nxt;
  logic [31:0] shift_r, shift_nxt;
  logic [31:0] seq_r, seq_nxt;
  logic [31:0] cmd_r, cmd_nxt;
  logic [15:0] len_r, len_nxt;
  logic [31:0] ret_r, ret_nxt;
  logic [31:0] crc_r, crc_nxt;
  logic        skip_r, skip_nxt;
  logic        match_r, match_nxt;

  logic [31:0] shift_new;
  logic [31:0] crc_upd;
  logic [16:0] len_ext;
  logic        done;
  kind_t       kind;
  err_t        err;
  logic        emit;

  assign shift_new = {shift_r[23:0], rx_byte};
  assign crc_upd   = crc32_byte(crc_r, rx_byte);
  assign len_ext   = {1'b0, len_r};

  // Parser next state and the result caused by the accepted item.
  always_comb begin
    stage_nxt = stage_r;
    pos_nxt   = pos_r;
    shift_nxt = shift_r;
    seq_nxt   = seq_r;
    cmd_nxt   = cmd_r;
    len_nxt   = len_r;
    ret_nxt   = ret_r;
    crc_nxt   = crc_r;
    skip_nxt  = skip_r;
    match_nxt = match_r;
    done      = 1'b0;
    emit      = 1'b0;
    kind      = KIND_PAYLOAD;
    err       = ERR_NONE;
    res       = '0;

    if (in_fire && !skip_r) begin
      shift_nxt = shift_new;
      pos_nxt   = pos_r + 17'd1;
      if (stage_r == ST_HEADER || stage_r == ST_RETCODE || stage_r == ST_DATA) begin
        crc_nxt = crc_upd;
      end

      case (stage_r)
        ST_HEADER: begin
          if (pos_r == POS_PREFIX_END && shift_new != cfg.prefix) begin
            kind = KIND_ERROR; err = ERR_PREFIX; done = 1'b1;
          end else if (pos_r == POS_SEQ_END) begin
            seq_nxt = shift_new;
          end else if (pos_r == POS_CMD_END) begin
            cmd_nxt = shift_new;
          end else if (pos_r == POS_LEN_END) begin
            if (shift_new < MIN_LENGTH) begin
              kind = KIND_ERROR; err = ERR_LEN_SMALL; done = 1'b1;
            end else if (shift_new > {16'd0, cfg.max_len}) begin
              kind = KIND_ERROR; err = ERR_LEN_MAX; done = 1'b1;
            end else begin
              len_nxt   = shift_new[15:0];
              stage_nxt = ST_RETCODE;
            end
          end
        end
        ST_RETCODE: begin
          if (pos_r == POS_RET_END) begin
            ret_nxt   = shift_new;
            stage_nxt = (len_r == MIN_LENGTH[15:0]) ? ST_CRC : ST_DATA;
          end
        end
        ST_DATA: begin
          kind = KIND_PAYLOAD;
          emit = 1'b1;
          if (pos_r == len_ext + 17'd7) begin
            stage_nxt = ST_CRC;
          end
        end
        ST_CRC: begin
          if (pos_r == len_ext + 17'd11) begin
            match_nxt = (shift_new == (crc_r ^ CRC_ONES));
            stage_nxt = ST_SUFFIX;
          end
        end
        default: begin
          if (pos_r >= len_ext + 17'd15) begin
            done = 1'b1;
            if (shift_new != cfg.suffix) begin
              kind = KIND_ERROR; err = ERR_SUFFIX;
            end else begin
              kind = KIND_COMPLETE;
            end
          end
        end
      endcase

      // A buffer that ends before the frame does gives short or truncated.
      if (!done && buffer_last) begin
        kind = KIND_ERROR;
        err  = (pos_r < POS_SHORT_LIM) ? ERR_SHORT : ERR_TRUNCATED;
        done = 1'b1;
      end

      emit = emit || done;
      res.kind    = kind;
      res.payload = (kind == KIND_PAYLOAD) ? rx_byte : 8'd0;
      res.seq     = (kind == KIND_PAYLOAD) ? 32'd0 : seq_nxt;
      res.cmd     = (kind == KIND_PAYLOAD) ? 32'd0 : cmd_nxt;
      res.ret     = (kind == KIND_COMPLETE) ? ret_r : 32'd0;
      res.ok      = (kind == KIND_COMPLETE) ? match_r : 1'b0;
      res.err     = err;

      if (done && !buffer_last) begin
        skip_nxt = 1'b1;
      end
    end

    // The end of a buffer always restarts parsing.
    if (in_fire && buffer_last) begin
      skip_nxt  = 1'b0;
      stage_nxt = ST_HEADER;
      pos_nxt   = '0;
      shift_nxt = '0;
      seq_nxt   = '0;
      cmd_nxt   = '0;
      len_nxt   = '0;
      ret_nxt   = '0;
      crc_nxt   = CRC_ONES;
      match_nxt = 1'b0;
    end
  end

  assign res_valid = emit;

  // Parser state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_r <= ST_HEADER;
      pos_r   <= '0;
      shift_r <= '0;
      seq_r   <= '0;
      cmd_r   <= '0;
      len_r   <= '0;
      ret_r   <= '0;
      crc_r   <= CRC_ONES;
      skip_r  <= 1'b0;
      match_r <= 1'b0;
    end else begin
      stage_r <= stage_nxt;
      pos_r   <= pos_nxt;
      shift_r <= shift_nxt;
      seq_r   <= seq_nxt;
      cmd_r   <= cmd_nxt;
      len_r   <= len_nxt;
      ret_r   <= ret_nxt;
      crc_r   <= crc_nxt;
      skip_r  <= skip_nxt;
      match_r <= match_nxt;
    end
  end

endmodule

// ===== design/dfr_queue.sv =====
// Short result queue between the parser and the output stage.
module dfr_queue #(
  parameter int DEPTH = 2
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  dfr_pkg::res_t push_data,
  output logic          has_room,
  input  logic          pop,
  output logic          not_empty,
  output dfr_pkg::res_t pop_data
);
  import dfr_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  res_t             entry_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic             do_push;
  logic             do_pop;

  assign has_room  = (count_r != CNT_FULL);
  assign not_empty = (count_r != '0);
  assign do_push   = push && has_room;
  assign do_pop    = pop && not_empty;
  assign pop_data  = entry_r[rd_ptr_r];

  // Entry storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_data;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count_r <= count_r - CNT_W'(1);
      end
    end
  end

endmodule

// ===== design/dfr_back.sv =====
// Back end: output register that drains the queue onto the result stream.
module dfr_back (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          q_valid,
  input  dfr_pkg::res_t q_data,
  output logic          q_pop,
  output logic          out_tvalid,
  input  logic          out_tready,
  output logic [111:0]  out_tdata,
  output logic [1:0]    out_tuser
);
  import dfr_pkg::*;

  logic valid_r;
  res_t data_r;

  assign q_pop = !valid_r || out_tready;

  // Output register: load when empty or when the held item is taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (q_pop) begin
      valid_r <= q_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop && q_valid) begin
      data_r <= q_data;
    end
  end

  // Pack the result fields onto the stream.
  assign out_tvalid = valid_r;
  assign out_tuser  = data_r.kind;
  assign out_tdata  = {4'd0, data_r.err, data_r.ok, data_r.ret, data_r.cmd,
                       data_r.seq, data_r.payload};

endmodule

// ===== design/crc32_checked_frame_deframer.sv =====
// A result item goes from the parser into the result queue, then into the output register, which drives out_tvalid.
// Throughput: one byte per cycle; the parser takes a byte whenever the result queue has room.
// The CRC-32 runs one byte per cycle in the parser; the queue and output register decouple stalls.
// Reset (rst_n low at a clock edge): registers return to defaults, parser to the header,
// queue and output register empty.
module crc32_checked_frame_deframer #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic         clk,
  input  logic         rst_n,
  // Configuration write port.
  input  logic         cfg_we,
  input  logic [1:0]   cfg_index,
  input  logic [31:0]  cfg_wdata,
  // Received bytes.
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [7:0]   in_tdata,   // [7:0] rx_byte
  input  logic         in_tlast,   // buffer_last
  // Result items.
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [111:0] out_tdata,  // [7:0] payload_byte, [39:8] sequence_number,
                                   // [71:40] command_code, [103:72] return_code,
                                   // [104] crc_ok, [107:105] error_code, rest 0
  output logic [1:0]   out_tuser   // [1:0] result_kind
);
  import dfr_pkg::*;

  cfg_t cfg_r;
  logic in_fire;
  logic res_valid;
  res_t res;
  logic q_room;
  logic q_valid;
  res_t q_data;
  logic q_pop;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.prefix  <= PREFIX_RESET;
      cfg_r.suffix  <= SUFFIX_RESET;
      cfg_r.max_len <= MAX_LEN_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_PREFIX:  cfg_r.prefix  <= cfg_wdata;
        REG_SUFFIX:  cfg_r.suffix  <= cfg_wdata;
        REG_MAX_LEN: cfg_r.max_len <= cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  assign in_tready = q_room;
  assign in_fire   = in_tvalid && q_room;

  dfr_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg_r),
    .in_fire     (in_fire),
    .rx_byte     (in_tdata),
    .buffer_last (in_tlast),
    .res_valid   (res_valid),
    .res         (res)
  );

  dfr_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_valid),
    .push_data (res),
    .has_room  (q_room),
    .pop       (q_pop),
    .not_empty (q_valid),
    .pop_data  (q_data)
  );

  dfr_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_data     (q_data),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule
